@@ hw/rtl/mm_pkg.sv @@
// ----------------------------------------------------------------------------
// mm_pkg
// Shared widths, codes, state, command and status types of the matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int ACT_W     = 2;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 35;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

    localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic res_done;
    } t_status;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] r, input int max_dim);
        logic [CFG_W-1:0] lim;
        lim = CFG_W'(max_dim);
        if (r == '0) begin
            return CFG_W'(1);
        end else if (r > lim) begin
            return lim;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/mm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mm_ctrl
// Configuration registers and the sequencer that walks rows, columns and
// the inner index of a compute item.
// ----------------------------------------------------------------------------
module mm_ctrl #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                           i_valid,
    input  logic [mm_pkg::ACT_W-1:0]       i_action,
    output logic                           o_stall,
    input  mm_pkg::t_status                i_status,
    output mm_pkg::t_cmd                   o_cmd
);

    localparam int CW = mm_pkg::CFG_W;
    localparam int XW = mm_pkg::IDX_W;

    logic [CW-1:0]   r_rows_a;
    logic [CW-1:0]   r_inner_len;
    logic [CW-1:0]   r_cols_b;
    mm_pkg::t_state  r_state;
    mm_pkg::t_state  n_state;
    logic [XW-1:0]   r_i;
    logic [XW-1:0]   r_j;
    logic [XW-1:0]   r_k;

    logic [CW-1:0]   w_nr;
    logic [CW-1:0]   w_nk;
    logic [CW-1:0]   w_nc;
    logic            w_accept;
    logic            w_last_k;
    logic            w_last_j;
    logic            w_last_elem;
    logic            w_rd;

    assign w_nr = mm_pkg::eff_dim(r_rows_a, MAX_DIM);
    assign w_nk = mm_pkg::eff_dim(r_inner_len, MAX_DIM);
    assign w_nc = mm_pkg::eff_dim(r_cols_b, MAX_DIM);

    assign w_accept    = i_valid && (r_state == mm_pkg::ST_IDLE);
    assign w_last_k    = (CW'(r_k) + CW'(1)) == w_nk;
    assign w_last_j    = (CW'(r_j) + CW'(1)) == w_nc;
    assign w_last_elem = w_last_j && ((CW'(r_i) + CW'(1)) == w_nr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mm_pkg::DIM_RESET;
            r_inner_len <= mm_pkg::DIM_RESET;
            r_cols_b    <= mm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mm_pkg::REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mm_pkg::REG_INNER_LEN: r_inner_len <= i_cfg_data;
                mm_pkg::REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mm_pkg::ST_IDLE: begin
                if (w_accept && (i_action == mm_pkg::ACT_COMPUTE)) begin
                    n_state = mm_pkg::ST_ISSUE;
                end
            end
            mm_pkg::ST_ISSUE: begin
                if (w_rd && w_last_k) begin
                    n_state = mm_pkg::ST_DRAIN;
                end
            end
            mm_pkg::ST_DRAIN: begin
                if (i_status.res_done) begin
                    n_state = w_last_elem ? mm_pkg::ST_IDLE : mm_pkg::ST_ISSUE;
                end
            end
            default: n_state = mm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        w_rd    = 1'b0;
        unique case (r_state)
            mm_pkg::ST_IDLE:  o_stall = 1'b0;
            mm_pkg::ST_ISSUE: w_rd    = (r_k != '0) || i_status.out_free;
            mm_pkg::ST_DRAIN: w_rd    = 1'b0;
            default:          o_stall = 1'b1;
        endcase
    end

    always_comb begin
        o_cmd.wr_a      = w_accept && (i_action == mm_pkg::ACT_LOAD_A);
        o_cmd.wr_b      = w_accept && (i_action == mm_pkg::ACT_LOAD_B);
        o_cmd.rd        = w_rd;
        o_cmd.first     = (r_k == '0);
        o_cmd.last_k    = w_last_k;
        o_cmd.last_elem = w_last_elem;
        o_cmd.i         = r_i;
        o_cmd.j         = r_j;
        o_cmd.k         = r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_action == mm_pkg::ACT_COMPUTE)) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end
            if (w_rd) begin
                r_k <= w_last_k ? '0 : r_k + XW'(1);
            end
            if ((r_state == mm_pkg::ST_DRAIN) && i_status.res_done && !w_last_elem) begin
                if (w_last_j) begin
                    r_j <= '0;
                    r_i <= r_i + XW'(1);
                end else begin
                    r_j <= r_j + XW'(1);
                end
            end
        end
    end

endmodule

@@ hw/rtl/mm_datapath.sv @@
// ----------------------------------------------------------------------------
// mm_datapath
// Element stores for A and B, multiply and accumulate pipeline and the
// output register.
// ----------------------------------------------------------------------------
module mm_datapath #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mm_pkg::t_cmd                     i_cmd,
    output mm_pkg::t_status                  o_status,
    input  logic [mm_pkg::IDX_W-1:0]         i_row,
    input  logic [mm_pkg::IDX_W-1:0]         i_col,
    input  logic signed [mm_pkg::VAL_W-1:0]  i_value,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [mm_pkg::IDX_W-1:0]         o_out_row,
    output logic [mm_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [mm_pkg::PROD_W-1:0] o_product,
    output logic                             o_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = ELEM_WIDTH;
    localparam int PW    = mm_pkg::PROD_W;
    localparam int XW    = mm_pkg::IDX_W;

    typedef struct packed {
        logic          v;
        logic          first;
        logic          last_k;
        logic          last_elem;
        logic [XW-1:0] row;
        logic [XW-1:0] col;
    } t_tag;

    logic signed [EW-1:0] mem_a [DEPTH];
    logic signed [EW-1:0] mem_b [DEPTH];

    logic signed [EW-1:0]   w_elem;
    logic                   w_wr_ok;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr_a;
    logic [AW-1:0]          w_raddr_b;
    logic signed [2*EW-1:0] w_mul;
    logic signed [63:0]     w_mul_ext;
    logic signed [PW-1:0]   w_sum;

    logic signed [EW-1:0] r_a_q;
    logic signed [EW-1:0] r_b_q;
    logic signed [PW-1:0] r_mul;
    logic signed [PW-1:0] r_acc;
    t_tag                 r_s1;
    t_tag                 r_s2;
    logic                 r_out_valid;
    logic [XW-1:0]        r_out_row;
    logic [XW-1:0]        r_out_col;
    logic signed [PW-1:0] r_out_product;
    logic                 r_out_last;

    assign w_elem    = EW'({16'b0, i_value});
    assign w_wr_ok   = ({1'b0, i_row} < 4'(MAX_DIM)) && ({1'b0, i_col} < 4'(MAX_DIM));
    assign w_waddr   = AW'(int'(i_row) * MAX_DIM + int'(i_col));
    assign w_raddr_a = AW'(int'(i_cmd.i) * MAX_DIM + int'(i_cmd.k));
    assign w_raddr_b = AW'(int'(i_cmd.k) * MAX_DIM + int'(i_cmd.j));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && w_wr_ok) begin
            mem_a[w_waddr] <= w_elem;
        end
        if (i_cmd.wr_b && w_wr_ok) begin
            mem_b[w_waddr] <= w_elem;
        end
        if (i_cmd.rd) begin
            r_a_q <= mem_a[w_raddr_a];
            r_b_q <= mem_b[w_raddr_b];
        end
    end

    assign w_mul     = r_a_q * r_b_q;
    assign w_mul_ext = 64'(w_mul);
    assign w_sum     = r_s2.first ? r_mul : r_acc + r_mul;

    always_ff @(posedge i_clk) begin
        r_s1.first     <= i_cmd.first;
        r_s1.last_k    <= i_cmd.last_k;
        r_s1.last_elem <= i_cmd.last_elem;
        r_s1.row       <= i_cmd.i;
        r_s1.col       <= i_cmd.j;
        r_s2.first     <= r_s1.first;
        r_s2.last_k    <= r_s1.last_k;
        r_s2.last_elem <= r_s1.last_elem;
        r_s2.row       <= r_s1.row;
        r_s2.col       <= r_s1.col;
        r_mul          <= w_mul_ext[PW-1:0];
        if (r_s2.v) begin
            r_acc <= w_sum;
        end
        if (!i_rst_n) begin
            r_s1.v <= 1'b0;
            r_s2.v <= 1'b0;
        end else begin
            r_s1.v <= i_cmd.rd;
            r_s2.v <= r_s1.v;
        end
    end

    assign o_status.res_done = r_s2.v && r_s2.last_k;
    assign o_status.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_status.res_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_status.res_done) begin
            r_out_row     <= r_s2.row;
            r_out_col     <= r_s2.col;
            r_out_product <= w_sum;
            r_out_last    <= r_s2.last_elem;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_product = r_out_product;
    assign o_last    = r_out_last;

endmodule

@@ hw/rtl/matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply
// Signed integer matrix multiplier with element loads and a compute item.
// ----------------------------------------------------------------------------
// Load items (A or B element) are taken one per cycle and give no result.
// A compute item emits rows_a * cols_b elements of C in row-major order,
// the final one flagged by o_last. Each element takes one registered read of
// each element store per inner step, then a registered multiply and the
// accumulate into the output register; the next element starts once the
// output register is free. While a compute item runs no input is taken;
// loads and a new compute are taken again while the final result still
// waits in the output register.
module matrix_multiply #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [mm_pkg::ACT_W-1:0]         i_action,
    input  logic [mm_pkg::IDX_W-1:0]         i_row,
    input  logic [mm_pkg::IDX_W-1:0]         i_col,
    input  logic signed [mm_pkg::VAL_W-1:0]  i_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [mm_pkg::IDX_W-1:0]         o_out_row,
    output logic [mm_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [mm_pkg::PROD_W-1:0] o_product,
    output logic                             o_last
);

    mm_pkg::t_cmd    w_cmd;
    mm_pkg::t_status w_status;

    mm_ctrl #(
        .MAX_DIM(MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .o_stall     (o_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_value   (i_value),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_out_row (o_out_row),
        .o_out_col (o_out_col),
        .o_product (o_product),
        .o_last    (o_last)
    );

endmodule

@@ hw/rtl/mm_checker.sv @@
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks of the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic [mm_pkg::ACT_W-1:0]         i_action,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic signed [mm_pkg::PROD_W-1:0] o_product,
    input logic                             o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_compute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_action == mm_pkg::ACT_COMPUTE)) |=> o_stall)
        else $error("input taken right after a compute item");

    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall)
        else $error("input taken while results of a compute are pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_product) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .i_action  (i_action),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_product (o_product),
    .o_last    (o_last)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the matrix multiplier. Random element loads and
// compute items run against a local model of the A and B stores. Every
// emitted C element is checked for row, column, dot product and last flag.
// Dimensions are reprogrammed between phases, out-of-range values included.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACT_W     = mm_pkg::ACT_W;
    localparam int IDX_W     = mm_pkg::IDX_W;
    localparam int VAL_W     = mm_pkg::VAL_W;
    localparam int PROD_W    = mm_pkg::PROD_W;
    localparam int CFG_W     = mm_pkg::CFG_W;
    localparam int CFG_IDX_W = mm_pkg::CFG_IDX_W;

    localparam logic [CFG_W-1:0]     DIM_RESET     = mm_pkg::DIM_RESET;
    localparam logic [ACT_W-1:0]     ACT_LOAD_A    = mm_pkg::ACT_LOAD_A;
    localparam logic [ACT_W-1:0]     ACT_LOAD_B    = mm_pkg::ACT_LOAD_B;
    localparam logic [ACT_W-1:0]     ACT_COMPUTE   = mm_pkg::ACT_COMPUTE;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = mm_pkg::REG_ROWS_A;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = mm_pkg::REG_INNER_LEN;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = mm_pkg::REG_COLS_B;

    localparam int DIM       = mm_pkg::MAX_DIM_DEF;
    localparam int HOLD_LEN  = 300;
    localparam int WD_LIMIT  = 4000;
    localparam int N_PHASES  = 12;
    localparam int PHASE_LEN = 34;

    localparam logic [ACT_W-1:0]     ACT_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]        action;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_mm_item;

    typedef struct {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [PROD_W-1:0] product;
        logic                     last;
    } t_c_elem;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data  = '0;
    logic                     i_valid     = 1'b0;
    logic [ACT_W-1:0]         i_action    = '0;
    logic [IDX_W-1:0]         i_row       = '0;
    logic [IDX_W-1:0]         i_col       = '0;
    logic signed [VAL_W-1:0]  i_value     = '0;
    logic                     i_stall     = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [IDX_W-1:0]         o_out_row;
    logic [IDX_W-1:0]         o_out_col;
    logic signed [PROD_W-1:0] o_product;
    logic                     o_last;

    t_mm_item pending_items[$];
    t_c_elem  c_expected[$];
    t_mm_item cur_item;

    logic signed [VAL_W-1:0] a_elems [DIM*DIM];
    logic signed [VAL_W-1:0] b_elems [DIM*DIM];
    bit                      a_written [DIM*DIM];
    bit                      b_written [DIM*DIM];

    logic [CFG_W-1:0] dim_rows  = DIM_RESET;
    logic [CFG_W-1:0] dim_inner = DIM_RESET;
    logic [CFG_W-1:0] dim_cols  = DIM_RESET;

    int  idle_mode  = 0;
    bit  hold_req   = 1'b0;
    bit  hold_done  = 1'b0;
    int  hold_left  = 0;
    int  errors     = 0;
    int  load_count = 0;
    int  quiet_cycles = 0;

    matrix_multiply u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_product   (o_product),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp_dim(input logic [CFG_W-1:0] r);
        if (r == '0) begin
            return 1;
        end else if (int'(r) > DIM) begin
            return DIM;
        end
        return int'(r);
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return CFG_W'($urandom_range(9, 15));
        end else if (r < 4) begin
            return CFG_W'(DIM);
        end else if (r < 9) begin
            return CFG_W'($urandom_range(4, 7));
        end
        return CFG_W'($urandom_range(1, 3));
    endfunction

    // store a load, or expand a compute into all C elements
    task automatic store_or_multiply(input t_mm_item it);
        int nr, nk, nc, i, j, k;
        longint acc;
        t_c_elem e;
        case (it.action)
            ACT_LOAD_A: a_elems[it.row*DIM + it.col] = it.value;
            ACT_LOAD_B: b_elems[it.row*DIM + it.col] = it.value;
            ACT_COMPUTE: begin
                nr = clamp_dim(dim_rows);
                nk = clamp_dim(dim_inner);
                nc = clamp_dim(dim_cols);
                for (i = 0; i < nr; i++) begin
                    for (j = 0; j < nc; j++) begin
                        acc = 0;
                        for (k = 0; k < nk; k++) begin
                            acc += longint'(a_elems[i*DIM + k]) * longint'(b_elems[k*DIM + j]);
                        end
                        e.row     = IDX_W'(i);
                        e.col     = IDX_W'(j);
                        e.product = acc[PROD_W-1:0];
                        e.last    = (i == nr - 1) && (j == nc - 1);
                        c_expected.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [ACT_W-1:0] action, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
        t_mm_item it;
        it.action = action;
        it.row    = row;
        it.col    = col;
        it.value  = value;
        pending_items.push_back(it);
        if (action == ACT_LOAD_A) begin
            a_written[row*DIM + col] = 1'b1;
        end else if (action == ACT_LOAD_B) begin
            b_written[row*DIM + col] = 1'b1;
        end
        if (action != ACT_NONE) begin
            load_count++;
        end
    endtask

    // fill any element the compute would read, then issue it
    task automatic push_compute();
        int nr, nk, nc, i, j, k;
        nr = clamp_dim(dim_rows);
        nk = clamp_dim(dim_inner);
        nc = clamp_dim(dim_cols);
        for (i = 0; i < nr; i++) begin
            for (k = 0; k < nk; k++) begin
                if (!a_written[i*DIM + k]) begin
                    push_item(ACT_LOAD_A, IDX_W'(i), IDX_W'(k), rand_value());
                end
            end
        end
        for (k = 0; k < nk; k++) begin
            for (j = 0; j < nc; j++) begin
                if (!b_written[k*DIM + j]) begin
                    push_item(ACT_LOAD_B, IDX_W'(k), IDX_W'(j), rand_value());
                end
            end
        end
        push_item(ACT_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        case (idx)
            REG_ROWS_A:    dim_rows  = d;
            REG_INNER_LEN: dim_inner = d;
            REG_COLS_B:    dim_cols  = d;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_valid || c_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int pct;
        pct = (idle_mode == 0) ? 25 : (idle_mode == 1) ? 61 : 0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                store_or_multiply(cur_item);
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0 && !chance(pct)) begin
                    cur_item = pending_items.pop_front();
                    i_valid  <= 1'b1;
                    i_action <= cur_item.action;
                    i_row    <= cur_item.row;
                    i_col    <= cur_item.col;
                    i_value  <= cur_item.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int pct;
        t_c_elem e;
        bit stall_next;
        pct = (idle_mode == 0) ? 61 : (idle_mode == 1) ? 25 : 0;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (c_expected.size() == 0) begin
                    $display("%0t: unexpected C element row %0d col %0d product %0d last %0d",
                             $time, o_out_row, o_out_col, o_product, o_last);
                    errors++;
                end else begin
                    e = c_expected.pop_front();
                    if (o_out_row !== e.row || o_out_col !== e.col ||
                        o_product !== e.product || o_last !== e.last) begin
                        $display("%0t: C exp (%0d,%0d) %0d last %0d, got (%0d,%0d) %0d last %0d",
                                 $time, e.row, e.col, e.product, e.last,
                                 o_out_row, o_out_col, o_product, o_last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_LEN;
                stall_next = 1'b1;
            end else begin
                stall_next = chance(pct);
            end
            i_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int p, k, r, target;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // single element, most negative operands
        write_reg(REG_ROWS_A, 4'd1);
        write_reg(REG_INNER_LEN, 4'd1);
        write_reg(REG_COLS_B, 4'd1);
        push_item(ACT_LOAD_A, 3'd0, 3'd0, 16'h8000);
        push_item(ACT_LOAD_B, 3'd0, 3'd0, 16'h8000);
        push_compute();
        push_item(ACT_NONE, 3'd7, 3'd7, 16'h7fff);
        wait_idle();

        // inner length above range clamps to full width: largest sum
        write_reg(REG_ROWS_A, 4'd1);
        write_reg(REG_INNER_LEN, 4'd15);
        write_reg(REG_COLS_B, 4'd1);
        write_reg(REG_SPARE, 4'd15);
        for (k = 0; k < DIM; k++) begin
            push_item(ACT_LOAD_A, 3'd0, IDX_W'(k), 16'h8000);
            push_item(ACT_LOAD_B, IDX_W'(k), 3'd0, 16'h8000);
        end
        push_compute();
        wait_idle();

        // zero dimensions act as one: most negative sum
        write_reg(REG_ROWS_A, 4'd0);
        write_reg(REG_INNER_LEN, 4'd8);
        write_reg(REG_COLS_B, 4'd0);
        for (k = 0; k < DIM; k++) begin
            push_item(ACT_LOAD_B, IDX_W'(k), 3'd0, 16'h7fff);
        end
        push_compute();
        wait_idle();

        for (p = 0; p < N_PHASES; p++) begin
            if (p == 8) begin
                write_reg(REG_ROWS_A, 4'd3);
                write_reg(REG_INNER_LEN, 4'd4);
                write_reg(REG_COLS_B, 4'd3);
            end else begin
                write_reg(REG_ROWS_A, rand_dim());
                write_reg(REG_INNER_LEN, rand_dim());
                write_reg(REG_COLS_B, rand_dim());
            end
            idle_mode <= (p < 4) ? 0 : (p < 8) ? 1 : 2;
            if (p == 8) begin
                hold_req <= 1'b1;
                push_compute();
            end
            target = load_count + PHASE_LEN;
            while (load_count < target) begin
                r = $urandom_range(0, 99);
                if (r < 9) begin
                    push_compute();
                end else if (r < 12) begin
                    push_item(ACT_NONE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
                end else begin
                    push_item(r < 56 ? ACT_LOAD_A : ACT_LOAD_B, IDX_W'($urandom),
                              IDX_W'($urandom), rand_value());
                end
            end
            push_compute();
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ matrix_multiply.f @@
hw/rtl/mm_pkg.sv
hw/rtl/mm_ctrl.sv
hw/rtl/mm_datapath.sv
hw/rtl/matrix_multiply.sv
hw/rtl/mm_checker.sv
sim/tb.sv
